// File: sv/anchored_random_gain_envelope_top_macros.svh
// assertion macros shared by the envelope block
`ifndef ANCHORED_RANDOM_GAIN_ENVELOPE_TOP_MACROS_SVH
`define ANCHORED_RANDOM_GAIN_ENVELOPE_TOP_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define ARGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define ARGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/arge_pkg.sv
// shared types and constants of the gain envelope block
`default_nettype none
package arge_pkg;

  localparam int SAMPLE_WIDTH    = 24;
  localparam int CTRL_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 17;
  localparam int DEPTH_WIDTH     = 17;

  localparam int DEF_MAX_CONTROL_POINTS = 64;
  localparam int DEF_MAX_SAMPLES        = 65536;

  // opcodes
  localparam logic OP_CONTROL = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SAMPLE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONTROL_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENVELOPE_DEPTH = 2'd2;

  localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE = 17'd65536;

  typedef struct packed {
    logic                           opcode;
    logic signed [CTRL_WIDTH-1:0]   control_value;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           end_of_buffer;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/arge_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module arge_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/arge_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module arge_div #(
  parameter int QW = 32,
  parameter int VW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [QW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic      [QW-1:0] quotient_o,
  output logic      [VW-1:0] remainder_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW:0]   diff;

  // one compare and subtract step
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// File: sv/arge_front.sv
// front end: takes requests, stores control points, queues sample jobs
`default_nettype none
module arge_front #(
  parameter int MAX_CONTROL_POINTS = 64,
  parameter int MAX_SAMPLES        = 65536
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   push_i,
  input  wire arge_pkg::in_item_t                     item_i,
  output logic                                        full_o,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]         last_i,
  input  wire logic                                   busy_i,
  input  wire logic                                   job_pop_i,
  output logic                                        job_valid_o,
  output logic signed [arge_pkg::SAMPLE_WIDTH-1:0]    job_sample_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]              job_index_o,
  output logic                                        job_end_o,
  output logic                                        we_o,
  output logic [$clog2(MAX_CONTROL_POINTS)-1:0]       waddr_o,
  output logic [arge_pkg::CTRL_WIDTH-1:0]             wdata_o
);
  import arge_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int AW = $clog2(MAX_CONTROL_POINTS);

  logic          accept;
  logic          acc_ctrl, acc_smp;
  logic          end_flag;
  logic [IW-1:0] idx_eff;
  logic [IW-1:0] six_q, six_d;
  logic [AW:0]   wix_q, wix_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] paddr_q;
  logic [CTRL_WIDTH-1:0] pdata_q;
  logic          wr_fire;

  logic signed [SAMPLE_WIDTH-1:0] qs_q [2];
  logic [IW-1:0]                  qi_q [2];
  logic                           qe_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o   = pend_q || (cnt_q == 2'd2);
  assign accept   = push_i && !full_o;
  assign acc_ctrl = accept && (item_i.opcode == OP_CONTROL);
  assign acc_smp  = accept && (item_i.opcode == OP_SAMPLE);

  // position within the buffer
  assign end_flag = six_q >= last_i;
  assign idx_eff  = end_flag ? last_i : six_q;

  // store write waits until no sample is in flight
  assign wr_fire = pend_q && !busy_i && (cnt_q == 2'd0);
  assign we_o    = wr_fire;
  assign waddr_o = paddr_q;
  assign wdata_o = pdata_q;

  // counters and pending write
  always_comb begin
    six_d  = six_q;
    wix_d  = wix_q;
    pend_d = pend_q && !wr_fire;
    if (acc_ctrl && (wix_q < (AW+1)'(MAX_CONTROL_POINTS))) begin
      pend_d = 1'b1;
      wix_d  = wix_q + (AW+1)'(1);
    end
    if (acc_smp) begin
      if (end_flag) begin
        six_d = '0;
        wix_d = '0;
      end else begin
        six_d = six_q + IW'(1);
      end
    end
  end

  // job queue occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (acc_smp && !job_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!acc_smp && job_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      six_q  <= '0;
      wix_q  <= '0;
      pend_q <= 1'b0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      six_q  <= six_d;
      wix_q  <= wix_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      if (acc_smp) begin
        wp_q <= !wp_q;
      end
      if (job_pop_i) begin
        rp_q <= !rp_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_ctrl) begin
      paddr_q <= wix_q[AW-1:0];
      pdata_q <= item_i.control_value;
    end
    if (acc_smp) begin
      qs_q[wp_q] <= item_i.sample_in;
      qi_q[wp_q] <= idx_eff;
      qe_q[wp_q] <= end_flag;
    end
  end

  assign job_valid_o  = cnt_q != 2'd0;
  assign job_sample_o = qs_q[rp_q];
  assign job_index_o  = qi_q[rp_q];
  assign job_end_o    = qe_q[rp_q];

endmodule
`default_nettype wire

// File: sv/arge_back.sv
// back end: interpolation, anchoring, gain and saturation sequencer
`default_nettype none
module arge_back #(
  parameter int MAX_CONTROL_POINTS = 64,
  parameter int MAX_SAMPLES        = 65536
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   job_valid_i,
  input  wire logic signed [arge_pkg::SAMPLE_WIDTH-1:0] job_sample_i,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]         job_index_i,
  input  wire logic                                   job_end_i,
  output logic                                        job_pop_o,
  output logic                                        busy_o,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]         last_i,
  input  wire logic [$clog2(MAX_CONTROL_POINTS)-1:0]  cpm1_i,
  input  wire logic [arge_pkg::DEPTH_WIDTH-1:0]       depth_i,
  output logic [$clog2(MAX_CONTROL_POINTS)-1:0]       raddr_o,
  input  wire logic [arge_pkg::CTRL_WIDTH-1:0]        rdata_i,
  input  wire logic                                   pop_i,
  output logic                                        res_valid_o,
  output arge_pkg::out_item_t                         res_o
);
  import arge_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int AW = $clog2(MAX_CONTROL_POINTS);
  localparam int SW = SAMPLE_WIDTH;
  localparam int DW = IW + 20;
  localparam int PW = DW + 18;
  localparam int VW = IW + 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_NUM  = 5'd1;
  localparam logic [4:0] S_D1S  = 5'd2;
  localparam logic [4:0] S_D1W  = 5'd3;
  localparam logic [4:0] S_RD0  = 5'd4;
  localparam logic [4:0] S_RD1  = 5'd5;
  localparam logic [4:0] S_RD2  = 5'd6;
  localparam logic [4:0] S_RD3  = 5'd7;
  localparam logic [4:0] S_RD4  = 5'd8;
  localparam logic [4:0] S_M0   = 5'd9;
  localparam logic [4:0] S_M1   = 5'd10;
  localparam logic [4:0] S_M2   = 5'd11;
  localparam logic [4:0] S_M3   = 5'd12;
  localparam logic [4:0] S_M4   = 5'd13;
  localparam logic [4:0] S_M5   = 5'd14;
  localparam logic [4:0] S_D2S  = 5'd15;
  localparam logic [4:0] S_D2W  = 5'd16;
  localparam logic [4:0] S_QC   = 5'd17;
  localparam logic [4:0] S_Y    = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;

  logic [4:0] state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       fin_fire;

  logic signed [SW-1:0] x_q;
  logic [IW-1:0]        i_q;
  logic                 end_q;
  logic                 pass_q;
  logic [IW+AW-1:0]     num_q;
  logic [AW-1:0]        i0_q;
  logic [AW-1:0]        i1;
  logic [IW-1:0]        r_q;
  logic signed [CTRL_WIDTH-1:0] c0_q, cl_q, ci0_q, ci1_q;
  logic signed [DW-1:0] acc_q;
  logic signed [PW-1:0] p_q;
  logic [PW-1:0]        qa_q;
  logic                 rnz_q;
  logic signed [32:0]   g_q, g_d;
  logic signed [SW+32:0] yp_q;

  logic                 div_start, div_done;
  logic [PW-1:0]        div_dividend, div_quo;
  logic [VW-1:0]        div_divisor, div_rem;

  logic signed [16:0]   ma;
  logic signed [IW+1:0] mb;
  logic signed [IW+18:0] mprod;
  logic signed [17:0]   dep_s;
  logic signed [34:0]   dprod_lo;
  logic signed [DW+1:0] dprod_hi;
  logic [IW:0]          dmr;
  logic                 neg;
  logic [PW-1:0]        mag;
  logic signed [PW:0]   qmag, qs, span_s, qc;
  logic signed [SW+32:0] ysum, ysh;
  logic                 sat_hi, sat_lo;
  logic [SW-1:0]        ysat;

  // shared divider for position and gain
  arge_div #(
    .QW(PW),
    .VW(VW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign div_start    = (state_q == S_D1S) || (state_q == S_D2S);
  assign div_dividend = (state_q == S_D1S) ? PW'(num_q) : mag;
  assign div_divisor  = (state_q == S_D1S) ? {1'b0, last_i} : {last_i, 1'b0};

  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign busy_o      = state_q != S_IDLE;
  assign fin_fire    = (state_q == S_FIN) && (!res_valid_q || pop_i);
  assign res_valid_o = res_valid_q;

  // next neighbor index, held at the last point
  assign i1 = (i0_q < cpm1_i) ? i0_q + AW'(1) : i0_q;

  // control store read address per step
  always_comb begin
    case (state_q)
      S_RD0:   raddr_o = '0;
      S_RD1:   raddr_o = cpm1_i;
      S_RD2:   raddr_o = i0_q;
      S_RD3:   raddr_o = i1;
      default: raddr_o = '0;
    endcase
  end

  // shared multiplier for the deviation terms
  assign dmr = {1'b0, last_i} - {1'b0, r_q};
  always_comb begin
    case (state_q)
      S_M0: begin
        ma = {ci0_q[CTRL_WIDTH-1], ci0_q};
        mb = $signed({1'b0, dmr});
      end
      S_M1: begin
        ma = {ci1_q[CTRL_WIDTH-1], ci1_q};
        mb = $signed({2'b00, r_q});
      end
      S_M2: begin
        ma = {c0_q[CTRL_WIDTH-1], c0_q};
        mb = $signed({2'b00, last_i});
      end
      S_M3: begin
        ma = {cl_q[CTRL_WIDTH-1], cl_q} - {c0_q[CTRL_WIDTH-1], c0_q};
        mb = $signed({2'b00, i_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign mprod = ma * mb;

  // depth times deviation in two partial products
  assign dep_s    = $signed({1'b0, depth_i});
  assign dprod_lo = dep_s * $signed({1'b0, acc_q[15:0]});
  assign dprod_hi = dep_s * $signed(acc_q[DW-1:16]);

  assign neg = p_q[PW-1];
  assign mag = neg ? PW'(-p_q) : PW'(p_q);

  // floor quotient, clamp to the depth span, add unity
  always_comb begin
    qmag   = $signed({1'b0, qa_q});
    qs     = neg ? (-qmag - $signed({{PW{1'b0}}, rnz_q})) : qmag;
    span_s = $signed({{(PW-30){1'b0}}, depth_i, 14'b0});
    if (qs > span_s) begin
      qc = span_s;
    end else if (qs < -span_s) begin
      qc = -span_s;
    end else begin
      qc = qs;
    end
    g_d = 33'sh040000000 + $signed(qc[32:0]);
  end

  // round half up and saturate
  always_comb begin
    ysum   = yp_q + $signed({{(SW+3){1'b0}}, 1'b1, 29'b0});
    ysh    = ysum >>> 30;
    sat_hi = !ysh[SW+32] && (|ysh[SW+32:SW-1]);
    sat_lo = ysh[SW+32] && !(&ysh[SW+32:SW-1]);
    if (sat_hi) begin
      ysat = {1'b0, {(SW-1){1'b1}}};
    end else if (sat_lo) begin
      ysat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      ysat = ysh[SW-1:0];
    end
  end

  // step sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = ((last_i == '0) || (depth_i == '0)) ? S_FIN : S_NUM;
        end
      end
      S_NUM:  state_d = S_D1S;
      S_D1S:  state_d = S_D1W;
      S_D1W:  if (div_done) state_d = S_RD0;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_RD4;
      S_RD4:  state_d = S_M0;
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_M5;
      S_M5:   state_d = S_D2S;
      S_D2S:  state_d = S_D2W;
      S_D2W:  if (div_done) state_d = S_QC;
      S_QC:   state_d = S_Y;
      S_Y:    state_d = S_FIN;
      S_FIN:  if (fin_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    res_valid_d = res_valid_q;
    if (fin_fire) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          x_q    <= job_sample_i;
          i_q    <= job_index_i;
          end_q  <= job_end_i;
          pass_q <= (last_i == '0) || (depth_i == '0);
        end
      end
      S_NUM:  num_q <= {{AW{1'b0}}, i_q} * {{IW{1'b0}}, cpm1_i};
      S_D1W: begin
        if (div_done) begin
          i0_q <= div_quo[AW-1:0];
          r_q  <= div_rem[IW-1:0];
        end
      end
      S_RD1:  c0_q  <= $signed(rdata_i);
      S_RD2:  cl_q  <= $signed(rdata_i);
      S_RD3:  ci0_q <= $signed(rdata_i);
      S_RD4:  ci1_q <= $signed(rdata_i);
      S_M0:   acc_q <= DW'(mprod);
      S_M1:   acc_q <= acc_q + DW'(mprod);
      S_M2:   acc_q <= acc_q - DW'(mprod);
      S_M3:   acc_q <= acc_q - DW'(mprod);
      S_M4:   p_q   <= PW'(dprod_lo);
      S_M5:   p_q   <= p_q + (PW'(dprod_hi) <<< 16);
      S_D2W: begin
        if (div_done) begin
          qa_q  <= div_quo;
          rnz_q <= div_rem != '0;
        end
      end
      S_QC:   g_q  <= g_d;
      S_Y:    yp_q <= x_q * g_q;
      S_FIN: begin
        if (fin_fire) begin
          res_o.sample_out    <= pass_q ? x_q : $signed(ysat);
          res_o.end_of_buffer <= end_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/anchored_random_gain_envelope_top.sv
// Gain envelope block top: config registers, front end, control store, back end.
// Interpolated samples use the bit-serial shared divider twice: position, then gain.
// The back end takes one sample at a time; the front end queues up to two jobs.
// Control-point requests wait for in-flight samples; pass-through samples skip the
// interpolation and division steps.
// Reset: asynchronous active low, returns counters, queues and config to defaults.
`default_nettype none
`include "anchored_random_gain_envelope_top_macros.svh"
module anchored_random_gain_envelope_top #(
  parameter int MAX_CONTROL_POINTS = arge_pkg::DEF_MAX_CONTROL_POINTS,
  parameter int MAX_SAMPLES        = arge_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire arge_pkg::in_item_t                   in_item_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output arge_pkg::out_item_t                       out_item_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [arge_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [arge_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);
  import arge_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int AW = $clog2(MAX_CONTROL_POINTS);

  logic [16:0] sample_count_q;
  logic [6:0]  control_count_q;
  logic [16:0] depth_q;
  logic [IW-1:0] last;
  logic [AW-1:0] cpm1;
  logic [DEPTH_WIDTH-1:0] depth_eff;

  logic          busy, job_pop, job_valid, job_end;
  logic signed [SAMPLE_WIDTH-1:0] job_sample;
  logic [IW-1:0] job_index;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CTRL_WIDTH-1:0] ram_wdata, ram_rdata;
  logic          res_valid;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q  <= '0;
      control_count_q <= 7'd3;
      depth_q         <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_COUNT:   sample_count_q  <= cfg_data_i;
        CFG_CONTROL_COUNT:  control_count_q <= cfg_data_i[6:0];
        CFG_ENVELOPE_DEPTH: depth_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped working values
  always_comb begin
    if (sample_count_q == '0) begin
      last = '0;
    end else if (32'(sample_count_q) > MAX_SAMPLES) begin
      last = IW'(MAX_SAMPLES - 1);
    end else begin
      last = IW'(sample_count_q - 17'd1);
    end
    if (control_count_q == '0) begin
      cpm1 = '0;
    end else if (32'(control_count_q) > MAX_CONTROL_POINTS) begin
      cpm1 = AW'(MAX_CONTROL_POINTS - 1);
    end else begin
      cpm1 = AW'(control_count_q - 7'd1);
    end
    depth_eff = (depth_q > DEPTH_ONE) ? DEPTH_ONE : depth_q;
  end

  arge_front #(
    .MAX_CONTROL_POINTS(MAX_CONTROL_POINTS),
    .MAX_SAMPLES       (MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (in_item_i),
    .full_o       (full),
    .last_i       (last),
    .busy_i       (busy),
    .job_pop_i    (job_pop),
    .job_valid_o  (job_valid),
    .job_sample_o (job_sample),
    .job_index_o  (job_index),
    .job_end_o    (job_end),
    .we_o         (ram_we),
    .waddr_o      (ram_waddr),
    .wdata_o      (ram_wdata)
  );

  arge_ram #(
    .WIDTH(CTRL_WIDTH),
    .DEPTH(MAX_CONTROL_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  arge_back #(
    .MAX_CONTROL_POINTS(MAX_CONTROL_POINTS),
    .MAX_SAMPLES       (MAX_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_sample_i (job_sample),
    .job_index_i  (job_index),
    .job_end_i    (job_end),
    .job_pop_o    (job_pop),
    .busy_o       (busy),
    .last_i       (last),
    .cpm1_i       (cpm1),
    .depth_i      (depth_eff),
    .raddr_o      (ram_raddr),
    .rdata_i      (ram_rdata),
    .pop_i        (pop),
    .res_valid_o  (res_valid),
    .res_o        (out_item_o)
  );

  assign empty = !res_valid;

  // store writes never overlap a sample in flight
  `ARGE_ASSERT_NOW(a_store_write_quiet, ram_we, !busy && !job_valid, "store write during sample")
  // back end only takes a queued job
  `ARGE_ASSERT_NOW(a_pop_needs_job, job_pop, job_valid, "job taken from empty queue")
  // a taken job keeps the back end busy
  `ARGE_ASSERT_NEXT(a_pop_starts_work, job_pop, busy, "job taken but back end idle")

endmodule
`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the anchored random gain envelope block
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import arge_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_WAIT  = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TARGET_ITEMS = 500;
  localparam int STORE_DEPTH  = DEF_MAX_CONTROL_POINTS;

  // expected-sample predictor and checker
  class gain_envelope_scoreboard;
    logic [16:0] sample_count_reg;
    logic [6:0]  control_count_reg;
    logic [16:0] depth_reg;
    shortint     control_pts[STORE_DEPTH];
    int          write_idx;
    int          sample_idx;
    out_item_t   expected_samples[$];
    int          mismatches;

    function void clear();
      sample_count_reg  = '0;
      control_count_reg = 7'd3;
      depth_reg         = '0;
      write_idx         = 0;
      sample_idx        = 0;
      mismatches        = 0;
      foreach (control_pts[k]) control_pts[k] = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] d);
      case (idx)
        CFG_SAMPLE_COUNT:   sample_count_reg = d;
        CFG_CONTROL_COUNT:  control_count_reg = d[6:0];
        CFG_ENVELOPE_DEPTH: depth_reg = d;
        default: ;
      endcase
    endfunction

    function int eff_len();
      int n;
      n = sample_count_reg;
      if (n > DEF_MAX_SAMPLES) n = DEF_MAX_SAMPLES;
      if (n == 0) n = 1;
      return n;
    endfunction

    function int eff_points();
      int cp;
      cp = control_count_reg;
      if (cp > STORE_DEPTH) cp = STORE_DEPTH;
      if (cp == 0) cp = 1;
      return cp;
    endfunction

    function int eff_depth();
      return (depth_reg > DEPTH_ONE) ? int'(DEPTH_ONE) : int'(depth_reg);
    endfunction

    // true when the next sample would read control points not yet loaded
    function bit needs_control();
      return eff_len() > 1 && eff_depth() != 0 && write_idx < eff_points();
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    // accepted input request: store a point or predict one sample
    function void note_request(in_item_t it);
      int        n, cp, dep, i;
      bit        last_one;
      longint    x, y, den, num, i0, r, i1, c0, cl, dv, g, span;
      out_item_t res;
      if (it.opcode == OP_CONTROL) begin
        if (write_idx < STORE_DEPTH) begin
          control_pts[write_idx] = it.control_value;
          write_idx++;
        end
        return;
      end
      n   = eff_len();
      cp  = eff_points();
      dep = eff_depth();
      i   = sample_idx;
      last_one = (i >= n - 1);
      if (last_one) i = n - 1;
      x = it.sample_in;
      y = x;
      if (n > 1 && dep != 0) begin
        den  = n - 1;
        num  = longint'(i) * (cp - 1);
        i0   = num / den;
        r    = num % den;
        i1   = (i0 + 1 < cp) ? i0 + 1 : i0;
        c0   = control_pts[0];
        cl   = control_pts[cp-1];
        dv   = control_pts[i0] * (den - r) + control_pts[i1] * r - c0 * den - (cl - c0) * i;
        span = longint'(dep) << 14;
        g    = (64'sd1 << 30) + floor_div(dep * dv, 2 * den);
        if (g > (64'sd1 << 30) + span) g = (64'sd1 << 30) + span;
        if (g < (64'sd1 << 30) - span) g = (64'sd1 << 30) - span;
        y = floor_div(x * g + (64'sd1 << 29), 64'sd1 << 30);
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
      end
      if (last_one) begin
        sample_idx = 0;
        write_idx  = 0;
      end else begin
        sample_idx = i + 1;
      end
      res.sample_out    = y[SAMPLE_WIDTH-1:0];
      res.end_of_buffer = last_one;
      expected_samples.push_back(res);
    endfunction

    // accepted result against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_samples.size() == 0) begin
        $display("%0t unexpected result: sample_out %0d end %0b", $time,
                 got.sample_out, got.end_of_buffer);
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $display("%0t sample_out mismatch: expected %0d actual %0d", $time,
                 want.sample_out, got.sample_out);
        mismatches++;
      end
      if (got.end_of_buffer !== want.end_of_buffer) begin
        $display("%0t end_of_buffer mismatch: expected %0b actual %0b", $time,
                 want.end_of_buffer, got.end_of_buffer);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push, full, empty, pop;
  in_item_t  in_item_i;
  out_item_t out_item_o;
  logic      cfg_valid_i, cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i;

  gain_envelope_scoreboard sb = new();
  int  cycles;
  int  items_sent;
  bit  hold_off_req;
  bit  sender_burst;
  bit  receiver_burst;

  anchored_random_gain_envelope_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one request into the block, with a random gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 29) == 0) sender_burst = !sender_burst;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_request(it);
    items_sent++;
  endtask

  task automatic send_control(input logic [CTRL_WIDTH-1:0] v);
    in_item_t it;
    it.opcode        = OP_CONTROL;
    it.control_value = v;
    it.sample_in     = SAMPLE_WIDTH'($urandom);
    send_item(it);
  endtask

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] x);
    in_item_t it;
    it.opcode        = OP_SAMPLE;
    it.control_value = CTRL_WIDTH'($urandom);
    it.sample_in     = x;
    send_item(it);
  endtask

  // wait until every expected sample has come, then let the block settle
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.expected_samples.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [CFG_DATA_WIDTH-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, d);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [CTRL_WIDTH-1:0] pick_point();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return CTRL_WIDTH'($urandom);
    endcase
  endfunction

  // result side: random pops, one long hold-off on request
  initial begin
    pop = 1'b0;
    receiver_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      gap = receiver_burst ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 29) == 0) receiver_burst = !receiver_burst;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result(out_item_o);
    end
  end

  // stimulus
  initial begin
    int phase_len;
    int n_sel;
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_item_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    cycles       = 0;
    items_sent   = 0;
    hold_off_req = 1'b0;
    sender_burst = 1'b0;
    sb.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: empty buffer, every sample flagged and passed through
    send_sample(24'h7fffff);
    send_sample(24'h800000);
    send_control(16'h1234);
    drain();

    // full depth, three points at both full-scale extremes and zero, short buffer
    write_register(CFG_SAMPLE_COUNT, 17'd5);
    write_register(CFG_CONTROL_COUNT, 17'd3);
    write_register(CFG_ENVELOPE_DEPTH, DEPTH_ONE);
    send_control(16'h7fff);
    send_control(16'h8000);
    send_control(16'h0000);
    send_sample(24'h7fffff);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'hffffff);
    send_sample(24'h000001);
    drain();

    // oversized depth, two points give unity gain
    write_register(CFG_ENVELOPE_DEPTH, 17'h1ffff);
    write_register(CFG_CONTROL_COUNT, 17'd2);
    send_control(16'h8000);
    send_control(16'h7fff);
    send_sample(24'h7fffff);
    send_sample(24'h800000);
    drain();

    // oversized point count and a long buffer, then length lowered mid-buffer
    write_register(CFG_CONTROL_COUNT, 17'd127);
    write_register(CFG_SAMPLE_COUNT, 17'h1ffff);
    while (sb.needs_control()) send_control(pick_point());
    send_sample(24'h400000);
    send_sample(24'hc00000);
    drain();
    write_register(CFG_SAMPLE_COUNT, 17'd2);
    send_sample(24'h7fffff);
    drain();

    // random phases
    while (items_sent < TARGET_ITEMS) begin
      n_sel = $urandom_range(0, 9);
      case (n_sel)
        0: write_register(CFG_SAMPLE_COUNT, 17'd0);
        1: write_register(CFG_SAMPLE_COUNT, 17'd1);
        2: write_register(CFG_SAMPLE_COUNT, 17'd2);
        3: write_register(CFG_SAMPLE_COUNT, ($urandom_range(0, 1) != 0) ? 17'h1ffff : 17'd65536);
        default: write_register(CFG_SAMPLE_COUNT, CFG_DATA_WIDTH'($urandom_range(3, 40)));
      endcase
      case ($urandom_range(0, 6))
        0: write_register(CFG_CONTROL_COUNT, 17'd0);
        1: write_register(CFG_CONTROL_COUNT, 17'd1);
        2: write_register(CFG_CONTROL_COUNT, 17'd64);
        3: write_register(CFG_CONTROL_COUNT, 17'd127);
        default: write_register(CFG_CONTROL_COUNT, CFG_DATA_WIDTH'($urandom_range(3, 64)));
      endcase
      case ($urandom_range(0, 6))
        0: write_register(CFG_ENVELOPE_DEPTH, 17'd0);
        1: write_register(CFG_ENVELOPE_DEPTH, 17'd1);
        2: write_register(CFG_ENVELOPE_DEPTH, DEPTH_ONE);
        3: write_register(CFG_ENVELOPE_DEPTH, 17'h1ffff);
        default: write_register(CFG_ENVELOPE_DEPTH, CFG_DATA_WIDTH'($urandom_range(0, 65536)));
      endcase
      phase_len = (n_sel == 3) ? $urandom_range(2, 6) : $urandom_range(10, 50);
      // now and then overfill the control store at a buffer start
      if (sb.sample_idx == 0 && $urandom_range(0, 7) == 0)
        repeat (STORE_DEPTH + $urandom_range(1, 6)) send_control(pick_point());
      repeat (phase_len) begin
        if (sb.needs_control() || $urandom_range(0, 6) == 0) send_control(pick_point());
        else send_sample(pick_sample());
      end
      drain();
    end

    // fill the block: fast pass-through samples while the receiver holds off
    write_register(CFG_SAMPLE_COUNT, 17'd7);
    write_register(CFG_ENVELOPE_DEPTH, 17'd0);
    hold_off_req = 1'b1;
    repeat (80) send_sample(pick_sample());
    drain();

    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
